@@ hdl/cwc_pkg.sv @@
// Shared types, constants and helpers of the congestion window controller.
`default_nettype none

package cwc_pkg;

	// Sequence numbers and window sizes are fixed at 16 bits by the port widths.
	localparam int SEQ_WIDTH   = 16;
	localparam int START_WIDTH = SEQ_WIDTH + 1;
	localparam int END_WIDTH   = SEQ_WIDTH + 2;
	localparam int CNT_WIDTH   = 16;
	localparam int DUP_WIDTH   = 8;
	localparam int CFG_WIDTH   = 16;
	localparam int OP_WIDTH    = 2;
	localparam int PHASE_WIDTH = 2;
	localparam int RTX_WIDTH   = 2;
	localparam int APB_DATA_WIDTH = 32;
	localparam int APB_ADDR_WIDTH = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SEQ_WIDTH-1:0] SEQ_MAX = '1;
	localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [DUP_WIDTH-1:0] DUP_MAX = '1;
	localparam logic [DUP_WIDTH-1:0] DUP_LIMIT = 8'd3;

	localparam logic [CFG_WIDTH-1:0] RST_PACKET_COUNT = 16'd1;
	localparam logic [CFG_WIDTH-1:0] RST_THRESHOLD    = 16'd14;

	// Register indexes on the configuration port (byte address bit 2).
	localparam logic REG_PACKET_COUNT      = 1'b0;
	localparam logic REG_INITIAL_THRESHOLD = 1'b1;

	localparam logic [OP_WIDTH-1:0] OP_ACK     = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_TIMEOUT = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_START   = 2'd2;

	localparam logic [PHASE_WIDTH-1:0] PH_SLOW  = 2'd0;
	localparam logic [PHASE_WIDTH-1:0] PH_AVOID = 2'd1;
	localparam logic [PHASE_WIDTH-1:0] PH_FAST  = 2'd2;

	localparam logic [RTX_WIDTH-1:0] RTX_NONE    = 2'd0;
	localparam logic [RTX_WIDTH-1:0] RTX_FAST    = 2'd1;
	localparam logic [RTX_WIDTH-1:0] RTX_TIMEOUT = 2'd2;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_ACK     = 2'd1,
		EV_TIMEOUT = 2'd2,
		EV_START   = 2'd3
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t             kind;
		logic [SEQ_WIDTH-1:0] seq;
	} ev_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic [CNT_WIDTH-1:0] sat_inc16(input logic [CNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [DUP_WIDTH-1:0] sat_inc_dup(input logic [DUP_WIDTH-1:0] v);
		return (v == DUP_MAX) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

@@ hdl/cwc_if.sv @@
// Channel interfaces for the event input and the window report output.
`default_nettype none

interface cwc_evt_if;
	logic                               valid;
	logic                               ready;
	logic [cwc_pkg::OP_WIDTH-1:0]       operation;
	logic [cwc_pkg::SEQ_WIDTH-1:0]      ack_seq;
	logic                               ack_checksum_ok;

	modport source(output valid, output operation, output ack_seq, output ack_checksum_ok,
		input ready);
	modport sink(input valid, input operation, input ack_seq, input ack_checksum_ok,
		output ready);
endinterface

interface cwc_res_if;
	logic                               valid;
	logic                               ready;
	logic [cwc_pkg::START_WIDTH-1:0]    window_start;
	logic [cwc_pkg::SEQ_WIDTH-1:0]      window_end;
	logic [cwc_pkg::SEQ_WIDTH-1:0]      window_size;
	logic [cwc_pkg::SEQ_WIDTH-1:0]      threshold;
	logic [cwc_pkg::PHASE_WIDTH-1:0]    phase;
	logic [cwc_pkg::RTX_WIDTH-1:0]      retransmit;
	logic                               transfer_done;

	modport source(output valid, output window_start, output window_end, output window_size,
		output threshold, output phase, output retransmit, output transfer_done, input ready);
	modport sink(input valid, input window_start, input window_end, input window_size,
		input threshold, input phase, input retransmit, input transfer_done, output ready);
endinterface

`default_nettype wire

@@ hdl/cwc_front.sv @@
// Front end: accepts event transactions and classifies them into event kinds.
`default_nettype none

module cwc_front (
	cwc_evt_if.sink          evt_ch,
	input  wire logic        q_full,
	output cwc_pkg::ev_t     push_ev,
	output logic             push
);

	always_comb begin
		push_ev.seq = evt_ch.ack_seq;
		case (evt_ch.operation)
			cwc_pkg::OP_ACK: begin
				// An acknowledgement that failed its checksum is turned into an empty event here.
				push_ev.kind = evt_ch.ack_checksum_ok ? cwc_pkg::EV_ACK : cwc_pkg::EV_NONE;
			end
			cwc_pkg::OP_TIMEOUT: begin
				push_ev.kind = cwc_pkg::EV_TIMEOUT;
			end
			cwc_pkg::OP_START: begin
				push_ev.kind = cwc_pkg::EV_START;
			end
			default: begin
				push_ev.kind = cwc_pkg::EV_NONE;
			end
		endcase
	end

	assign evt_ch.ready = !q_full;
	assign push         = evt_ch.valid && !q_full;

endmodule

`default_nettype wire

@@ hdl/cwc_queue.sv @@
// Small event queue between the front end and the back end.
`default_nettype none

module cwc_queue #(
	parameter int DEPTH = cwc_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cwc_pkg::ev_t   push_ev,
	input  wire logic           pop,
	output cwc_pkg::ev_t        head_ev,
	output cwc_pkg::q_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cwc_pkg::ev_t       slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_ev    = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_FULL);

endmodule

`default_nettype wire

@@ hdl/cwc_back.sv @@
// Back end: applies one event per cycle to the window state, unless the output stalls, and registers the report.
`default_nettype none

module cwc_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [cwc_pkg::CFG_WIDTH-1:0]   packet_count,
	input  wire logic [cwc_pkg::CFG_WIDTH-1:0]   initial_threshold,
	input  wire cwc_pkg::ev_t                    head_ev,
	input  wire cwc_pkg::q_stat_t                stat,
	output logic                                 pop,
	cwc_res_if.source                            res_ch
);

	logic [cwc_pkg::START_WIDTH-1:0] start_q, n_start;
	logic [cwc_pkg::SEQ_WIDTH-1:0]   end_q, n_end;
	logic [cwc_pkg::SEQ_WIDTH-1:0]   size_q, n_size;
	logic [cwc_pkg::SEQ_WIDTH-1:0]   thr_q, n_thr;
	logic [cwc_pkg::PHASE_WIDTH-1:0] phase_q, n_phase;
	logic [cwc_pkg::SEQ_WIDTH-1:0]   last_q, n_last;
	logic [cwc_pkg::DUP_WIDTH-1:0]   dup_q, n_dup;
	logic [cwc_pkg::CNT_WIDTH-1:0]   avoid_q, n_avoid;
	logic [cwc_pkg::RTX_WIDTH-1:0]   n_rtx;
	logic                            end_en;

	logic                            done_now;
	logic                            new_ack;
	logic [cwc_pkg::SEQ_WIDTH-1:0]   size_inc;
	logic [cwc_pkg::CNT_WIDTH-1:0]   avoid_inc;
	logic [cwc_pkg::DUP_WIDTH-1:0]   dup_next;
	logic                            seq_dup;
	logic [cwc_pkg::SEQ_WIDTH:0]     fast_size;
	logic [cwc_pkg::END_WIDTH-1:0]   end_sum;
	logic [cwc_pkg::END_WIDTH-1:0]   end_val;

	logic                            res_valid_q;
	logic [cwc_pkg::START_WIDTH-1:0] res_start_q;
	logic [cwc_pkg::SEQ_WIDTH-1:0]   res_end_q;
	logic [cwc_pkg::SEQ_WIDTH-1:0]   res_size_q;
	logic [cwc_pkg::SEQ_WIDTH-1:0]   res_thr_q;
	logic [cwc_pkg::PHASE_WIDTH-1:0] res_phase_q;
	logic [cwc_pkg::RTX_WIDTH-1:0]   res_rtx_q;
	logic                            res_done_q;

	assign pop       = !stat.empty && (!res_valid_q || res_ch.ready);
	assign done_now  = start_q > {1'b0, packet_count};
	assign new_ack   = {1'b0, head_ev.seq} >= start_q;
	assign size_inc  = cwc_pkg::sat_inc16(size_q);
	assign avoid_inc = cwc_pkg::sat_inc16(avoid_q);
	assign seq_dup   = (head_ev.seq == last_q);
	assign dup_next  = seq_dup ? cwc_pkg::sat_inc_dup(dup_q) : dup_q;
	assign fast_size = {2'b0, size_q[cwc_pkg::SEQ_WIDTH-1:1]} + (cwc_pkg::SEQ_WIDTH+1)'(3);

	always_comb begin
		n_start = start_q;
		n_end   = end_q;
		n_size  = size_q;
		n_thr   = thr_q;
		n_phase = phase_q;
		n_last  = last_q;
		n_dup   = dup_q;
		n_avoid = avoid_q;
		n_rtx   = cwc_pkg::RTX_NONE;
		end_en  = 1'b0;
		case (head_ev.kind)
			cwc_pkg::EV_START: begin
				n_start = cwc_pkg::START_WIDTH'(1);
				n_end   = cwc_pkg::SEQ_WIDTH'(1);
				n_size  = cwc_pkg::SEQ_WIDTH'(1);
				n_thr   = initial_threshold;
				n_phase = cwc_pkg::PH_SLOW;
				n_last  = '0;
				n_dup   = '0;
				n_avoid = '0;
			end
			cwc_pkg::EV_TIMEOUT: begin
				if (!done_now) begin
					n_thr   = size_q >> 1;
					n_size  = cwc_pkg::SEQ_WIDTH'(1);
					n_phase = cwc_pkg::PH_SLOW;
					n_dup   = '0;
					n_rtx   = cwc_pkg::RTX_TIMEOUT;
					end_en  = 1'b1;
				end
			end
			cwc_pkg::EV_ACK: begin
				if (!done_now) begin
					if (new_ack) begin
						case (phase_q)
							cwc_pkg::PH_SLOW: begin
								n_start = {1'b0, head_ev.seq} + 1'b1;
								n_last  = head_ev.seq;
								n_dup   = '0;
								end_en  = 1'b1;
								if (size_inc >= thr_q) begin
									// Reaching the threshold handles the same ack
									// once more as an avoidance ack.
									n_phase = cwc_pkg::PH_AVOID;
									if (size_inc == cwc_pkg::SEQ_WIDTH'(1)) begin
										n_size  = cwc_pkg::sat_inc16(size_inc);
										n_avoid = '0;
									end else begin
										n_size  = size_inc;
										n_avoid = cwc_pkg::CNT_WIDTH'(1);
									end
								end else begin
									n_size  = size_inc;
									n_avoid = '0;
								end
							end
							cwc_pkg::PH_AVOID: begin
								n_start = {1'b0, head_ev.seq} + 1'b1;
								n_last  = head_ev.seq;
								n_dup   = '0;
								end_en  = 1'b1;
								if (avoid_inc == size_q) begin
									n_size  = size_inc;
									n_avoid = '0;
								end else begin
									n_avoid = avoid_inc;
								end
							end
							cwc_pkg::PH_FAST: begin
								n_start = {1'b0, head_ev.seq} + 1'b1;
								n_last  = head_ev.seq;
								n_dup   = '0;
								n_avoid = '0;
								n_phase = cwc_pkg::PH_AVOID;
								n_size  = thr_q;
								end_en  = 1'b1;
							end
							default: begin
								n_phase = phase_q;
							end
						endcase
					end else begin
						n_dup = dup_next;
						if (seq_dup && (dup_next > cwc_pkg::DUP_LIMIT)) begin
							n_size = size_inc;
						end
						// Fast recovery is entered again whenever the count sits at
						// the limit, even for an old ack that is not a duplicate.
						if (dup_next == cwc_pkg::DUP_LIMIT) begin
							n_phase = cwc_pkg::PH_FAST;
							n_thr   = size_q >> 1;
							n_size  = fast_size[cwc_pkg::SEQ_WIDTH] ? cwc_pkg::SEQ_MAX
							                                        : fast_size[cwc_pkg::SEQ_WIDTH-1:0];
							n_rtx   = cwc_pkg::RTX_FAST;
							end_en  = 1'b1;
						end
					end
				end
			end
			default: begin
				n_rtx = cwc_pkg::RTX_NONE;
			end
		endcase

		// Window end from the final start and size, clamped to the packet count.
		end_sum = {1'b0, n_start} + {2'b0, n_size};
		end_val = (end_sum == '0) ? '0 : end_sum - 1'b1;
		if (end_val >= {2'b0, packet_count}) begin
			end_val = {2'b0, packet_count};
		end
		if (end_val > {2'b0, cwc_pkg::SEQ_MAX}) begin
			end_val = {2'b0, cwc_pkg::SEQ_MAX};
		end
		if (end_en) begin
			n_end = end_val[cwc_pkg::SEQ_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= cwc_pkg::START_WIDTH'(1);
			end_q       <= cwc_pkg::SEQ_WIDTH'(1);
			size_q      <= cwc_pkg::SEQ_WIDTH'(1);
			thr_q       <= cwc_pkg::RST_THRESHOLD;
			phase_q     <= cwc_pkg::PH_SLOW;
			last_q      <= '0;
			dup_q       <= '0;
			avoid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				start_q <= n_start;
				end_q   <= n_end;
				size_q  <= n_size;
				thr_q   <= n_thr;
				phase_q <= n_phase;
				last_q  <= n_last;
				dup_q   <= n_dup;
				avoid_q <= n_avoid;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_start_q <= n_start;
			res_end_q   <= n_end;
			res_size_q  <= n_size;
			res_thr_q   <= n_thr;
			res_phase_q <= n_phase;
			res_rtx_q   <= n_rtx;
			res_done_q  <= n_start > {1'b0, packet_count};
		end
	end

	assign res_ch.valid         = res_valid_q;
	assign res_ch.window_start  = res_start_q;
	assign res_ch.window_end    = res_end_q;
	assign res_ch.window_size   = res_size_q;
	assign res_ch.threshold     = res_thr_q;
	assign res_ch.phase         = res_phase_q;
	assign res_ch.retransmit    = res_rtx_q;
	assign res_ch.transfer_done = res_done_q;

endmodule

`default_nettype wire

@@ hdl/congestion_window_controller_top.sv @@
// Top level of the congestion window controller: configuration port and front/back split.
// An accepted event transaction is written into the event queue; the back end pops it and
// applies it to the window state and the report register when that register is free or being taken.
// Throughput: one event per cycle while each report is taken as soon as it is offered.
// The two-entry event queue keeps taking events, until full, while a report waits on the output.
// Reset (arst_n low, asynchronous): window start, end and size 1, threshold 14, slow start,
// counters zero, queue and output empty, packet_count 1 and initial_threshold 14.
`default_nettype none

module congestion_window_controller_top #(
	parameter int QUEUE_DEPTH = cwc_pkg::QUEUE_DEPTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	cwc_evt_if.sink                                   evt_ch,
	cwc_res_if.source                                 res_ch,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [cwc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
	input  wire logic [cwc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
	output logic [cwc_pkg::APB_DATA_WIDTH-1:0]        prdata,
	output logic                                      pready
);

	// Configuration registers. Address bit 2 selects the register; the two
	// low address bits are not decoded. Writes land in the access phase.
	logic [cwc_pkg::CFG_WIDTH-1:0] packet_count_q;
	logic [cwc_pkg::CFG_WIDTH-1:0] initial_threshold_q;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_count_q      <= cwc_pkg::RST_PACKET_COUNT;
			initial_threshold_q <= cwc_pkg::RST_THRESHOLD;
		end else if (cfg_wr) begin
			case (paddr[2])
				cwc_pkg::REG_PACKET_COUNT: begin
					packet_count_q <= pwdata[cwc_pkg::CFG_WIDTH-1:0];
				end
				cwc_pkg::REG_INITIAL_THRESHOLD: begin
					initial_threshold_q <= pwdata[cwc_pkg::CFG_WIDTH-1:0];
				end
				default: begin
					packet_count_q <= packet_count_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cwc_pkg::REG_PACKET_COUNT: begin
				prdata = {{(cwc_pkg::APB_DATA_WIDTH-cwc_pkg::CFG_WIDTH){1'b0}}, packet_count_q};
			end
			cwc_pkg::REG_INITIAL_THRESHOLD: begin
				prdata = {{(cwc_pkg::APB_DATA_WIDTH-cwc_pkg::CFG_WIDTH){1'b0}},
				          initial_threshold_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Front end classifies each event transaction and pushes it into the queue.
	cwc_pkg::ev_t     push_ev;
	cwc_pkg::ev_t     head_ev;
	cwc_pkg::q_stat_t q_stat;
	logic             push;
	logic             pop;

	cwc_front u_front (
		.evt_ch  (evt_ch),
		.q_full  (q_stat.full),
		.push_ev (push_ev),
		.push    (push)
	);

	cwc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.pop     (pop),
		.head_ev (head_ev),
		.stat    (q_stat)
	);

	// Back end owns the window state and the output register. It pops one
	// event whenever the output register is free or being emptied.
	cwc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.packet_count      (packet_count_q),
		.initial_threshold (initial_threshold_q),
		.head_ev           (head_ev),
		.stat              (q_stat),
		.pop               (pop),
		.res_ch            (res_ch)
	);

	// The queue never reports full and empty at the same time.
	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// The back end only takes an event that the queue holds.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("back end popped an empty queue");

	// An event pushed into an empty queue is visible to the back end next cycle.
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_stat.empty) |=> !q_stat.empty)
		else $error("pushed event lost by the queue");

endmodule

`default_nettype wire
